### sv/fixed_block_pool_allocator_assert.svh
// Assertion macros for the pool allocator checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, quiet while i_rst_n is low.
`define FBPA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, quiet while i_rst_n is low.
`define FBPA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/fbpa_pkg.sv
package fbpa_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 13;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 2;
    localparam int CFG_W    = 32;

    localparam int M_DATA_BITS = STATUS_W + ADDR_W + COUNT_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    localparam int OUT_STATUS_LO = 0;
    localparam int OUT_ADDR_LO   = OUT_STATUS_LO + STATUS_W;
    localparam int OUT_COUNT_LO  = OUT_ADDR_LO + ADDR_W;

    localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1024);

    localparam logic [INDEX_W-1:0] REG_BASE  = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_SIZE  = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] REG_COUNT = INDEX_W'(2);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

endpackage

### sv/fixed_block_pool_allocator.sv
// Pool allocator for equal-sized slots with a LIFO free list held in a single-port-write,
// registered-read link memory. One request is worked at a time and gives one response.
// After reset and after every write to a known register the link memory is rebuilt by a
// sweep over all CAPACITY slots (slot i links to slot i+1, the last live slot to the list
// end), during which no request is taken; a register write also clears the in-use count.
// Once idle, an allocate reads the head from link memory, then adds the slot address; an
// allocate on an empty pool goes straight to its response; a free runs the slot-index
// divider (one quotient bit per cycle over 11 bits) before the link write. A new request
// is taken as soon as the previous response is registered, even if not yet collected.
module fixed_block_pool_allocator #(
    parameter int CAPACITY = fbpa_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fbpa_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_s_axis_tdata,  // [31:0] address
    input  logic [0:0]                    i_s_axis_tuser,  // [0] cmd
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [fbpa_pkg::M_DATA_W-1:0] o_m_axis_tdata   // [1:0] status, [33:2] slot_address,
                                                           // [44:34] in_use_count, [47:45] zero
);
    import fbpa_pkg::*;

    localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW    = $clog2(CAPACITY + 1);
    localparam int PRW   = LW + SIZE_W;
    localparam int PW    = COUNT_W + SIZE_W;
    localparam int STEPW = $clog2(COUNT_W);

    localparam logic [LW-1:0] LINK_END = LW'(CAPACITY);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_FCHK,
        S_DIV,
        S_FREE,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [LW-1:0]        r_sweep;
    logic [LW-1:0]        r_head;
    logic [COUNT_W-1:0]   r_used;
    logic [ADDR_W-1:0]    r_base;
    logic [SIZE_W-1:0]    r_size;
    logic [COUNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]    r_offset;
    logic [PW-1:0]        r_pool;
    logic [PRW-1:0]       r_prod;
    logic [PW-1:0]        r_rem;
    logic [COUNT_W-1:0]   r_quo;
    logic [STEPW-1:0]     r_step;
    t_status              r_res_status;
    logic [ADDR_W-1:0]    r_res_addr;
    logic                 r_m_valid;
    logic [M_DATA_W-1:0]  r_m_data;
    logic [LW-1:0]        r_rd_data;

    logic [LW-1:0]        link_mem [CAPACITY];

    logic [COUNT_W-1:0]   live_cnt;
    logic                 head_empty;
    logic                 s_accept;
    logic                 cfg_hit;
    logic                 m_load;
    logic [PW-1:0]        div_trial;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [LW-1:0]        mem_wdata;
    logic                 mem_re;

    assign live_cnt   = (32'(r_count) < 32'(CAPACITY)) ? r_count : COUNT_W'(CAPACITY);
    assign head_empty = 32'(r_head) >= 32'(live_cnt);
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_hit    = i_cfg_wr_en &&
                        (i_cfg_index == REG_BASE || i_cfg_index == REG_SIZE ||
                         i_cfg_index == REG_COUNT);
    assign m_load     = (r_state == S_DONE) && !cfg_hit && (!r_m_valid || i_m_axis_tready);
    assign div_trial  = PW'(r_size) << r_step;

    assign o_s_axis_tready = (r_state == S_IDLE) && !cfg_hit;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep[IW-1:0];
        mem_wdata = (32'(r_sweep) + 32'd1 < 32'(live_cnt)) ? LW'(r_sweep + 1'b1) : LINK_END;
        mem_re    = 1'b0;
        if (r_state == S_SWEEP && !cfg_hit) begin
            mem_we = 1'b1;
        end else if (r_state == S_FREE && r_rem == '0 && !cfg_hit) begin
            mem_we    = 1'b1;
            mem_waddr = IW'(r_quo);
            mem_wdata = r_head;
        end
        if (s_accept && i_s_axis_tuser[0] == CMD_ALLOC && !head_empty) begin
            mem_re = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= link_mem[r_head[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_sweep   <= '0;
            r_head    <= LINK_END;
            r_used    <= '0;
            r_base    <= BASE_RST;
            r_size    <= SIZE_RST;
            r_count   <= COUNT_RST;
            r_m_valid <= 1'b0;
        end else begin
            if (m_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= M_DATA_W'({r_used, r_res_addr, r_res_status});
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (cfg_hit) begin
                unique case (i_cfg_index)
                    REG_BASE:  r_base  <= i_cfg_wr_data;
                    REG_SIZE:  r_size  <= i_cfg_wr_data[SIZE_W-1:0];
                    REG_COUNT: r_count <= i_cfg_wr_data[COUNT_W-1:0];
                    default:   r_base  <= r_base;
                endcase
                r_state <= S_SWEEP;
                r_sweep <= '0;
                r_used  <= '0;
            end else begin
                unique case (r_state)
                    S_SWEEP: begin
                        r_sweep <= r_sweep + 1'b1;
                        if (r_sweep == LW'(CAPACITY - 1)) begin
                            r_head  <= (live_cnt != '0) ? '0 : LINK_END;
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        r_res_addr   <= '0;
                        r_res_status <= (i_s_axis_tuser[0] == CMD_ALLOC && head_empty) ?
                                        ST_EXHAUSTED : ST_OK;
                        r_offset     <= i_s_axis_tdata - r_base;
                        r_pool       <= PW'(live_cnt) * PW'(r_size);
                        r_prod       <= PRW'(r_head) * PRW'(r_size);
                        if (s_accept) begin
                            if (i_s_axis_tuser[0] == CMD_FREE) begin
                                r_state <= S_FCHK;
                            end else if (head_empty) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_ALLOC;
                            end
                        end
                    end
                    S_ALLOC: begin
                        r_head     <= r_rd_data;
                        r_res_addr <= r_base + ADDR_W'(r_prod);
                        if (r_used < live_cnt) begin
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                    S_FCHK: begin
                        r_rem  <= PW'(r_offset);
                        r_quo  <= '0;
                        r_step <= STEPW'(COUNT_W - 1);
                        if (r_offset >= ADDR_W'(r_pool) || r_used == '0 || r_size == '0) begin
                            r_res_status <= ST_REJECTED;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                    S_DIV: begin
                        if (r_rem >= div_trial) begin
                            r_rem           <= r_rem - div_trial;
                            r_quo[r_step]   <= 1'b1;
                        end
                        r_step <= r_step - 1'b1;
                        if (r_step == '0) begin
                            r_state <= S_FREE;
                        end
                    end
                    S_FREE: begin
                        if (r_rem != '0) begin
                            r_res_status <= ST_REJECTED;
                        end else begin
                            r_head <= LW'(r_quo);
                            r_used <= r_used - 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                    S_DONE: begin
                        if (m_load) begin
                            r_state <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_SWEEP;
                        r_sweep <= '0;
                    end
                endcase
            end
        end
    end

endmodule

### sv/fbpa_checker.sv
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [fbpa_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic                          i_s_axis_tvalid,
    input  logic                          o_s_axis_tready,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [fbpa_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import fbpa_pkg::*;

    `FBPA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && o_m_axis_tvalid, "response changed while stalled")
    `FBPA_ASSERT_NOW(a_addr_zero, o_m_axis_tvalid && o_m_axis_tdata[OUT_ADDR_LO-1:0] != ST_OK, o_m_axis_tdata[OUT_COUNT_LO-1:OUT_ADDR_LO] == '0, "slot address set on failed request")
    `FBPA_ASSERT_NEXT(a_one_at_a_time, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "second request taken before response")
    `FBPA_ASSERT_NEXT(a_cfg_rebuild, i_cfg_wr_en && (i_cfg_index == REG_BASE || i_cfg_index == REG_SIZE || i_cfg_index == REG_COUNT), !o_s_axis_tready, "request taken during list rebuild")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr_en     (i_cfg_wr_en),
    .i_cfg_index     (i_cfg_index),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
